// File: rtl/lobm_pkg.sv
// ----------------------------------------------------------------------------
// lobm_pkg
// Shared types and constants for the limit order book matcher.
// ----------------------------------------------------------------------------
package lobm_pkg;

	localparam int MAX_RESTING_DEF = 32;
	localparam int MAX_STOPS_DEF   = 16;
	localparam int PRICE_TICKS_DEF = 1024;

	localparam logic [1:0] FUNC_LIMIT  = 2'd0;
	localparam logic [1:0] FUNC_MARKET = 2'd1;
	localparam logic [1:0] FUNC_STOP   = 2'd2;

	localparam logic [2:0] ST_RESTED     = 3'd0;
	localparam logic [2:0] ST_STOP_STORE = 3'd1;
	localparam logic [2:0] ST_NO_REST    = 3'd2;
	localparam logic [2:0] ST_BOOK_FULL  = 3'd3;
	localparam logic [2:0] ST_STOPS_FULL = 3'd4;

	// resting order held in one book cell
	typedef struct packed {
		logic        vld;
		logic [31:0] id;
		logic [15:0] ses;
		logic        buy;
		logic [9:0]  price;
		logic [31:0] qty;
		logic [31:0] seq;
	} rest_t;

	// stored stop order held in one stop cell
	typedef struct packed {
		logic        vld;
		logic [31:0] id;
		logic [15:0] ses;
		logic        buy;
		logic [9:0]  price;
		logic [31:0] qty;
		logic [31:0] seq;
		logic        pend;
	} stop_t;

	// best candidate passed down the book chain
	typedef struct packed {
		logic        found;
		logic [4:0]  idx;
		logic [9:0]  price;
		logic [31:0] age;
	} best_t;

	// oldest pending stop passed down the stop chain
	typedef struct packed {
		logic        found;
		logic [3:0]  idx;
		logic [31:0] age;
	} sbest_t;

endpackage

// File: rtl/lobm_book_cell.sv
// ----------------------------------------------------------------------------
// lobm_book_cell
// One book cell: compares its resting order with the best candidate from the
// previous cell and registers the winner for the next cell.
// ----------------------------------------------------------------------------
module lobm_book_cell #(
	parameter int IDX = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lobm_pkg::rest_t      ent,
	input  logic                 taker_buy,
	input  logic [31:0]          arrival,
	input  lobm_pkg::best_t      best_in,
	output lobm_pkg::best_t      best_q
);
	logic [31:0]     age;
	logic            cand;
	logic            better;
	lobm_pkg::best_t nxt;

	always_comb begin
		age    = arrival - ent.seq;
		cand   = ent.vld && (ent.buy != taker_buy);
		better = taker_buy ? (ent.price < best_in.price) : (ent.price > best_in.price);
		nxt    = best_in;
		if (cand && (!best_in.found || better ||
				(ent.price == best_in.price && age > best_in.age))) begin
			nxt.found = 1'b1;
			nxt.idx   = 5'(IDX);
			nxt.price = ent.price;
			nxt.age   = age;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= '0;
		end else begin
			best_q <= nxt;
		end
	end
endmodule

// File: rtl/lobm_stop_cell.sv
// ----------------------------------------------------------------------------
// lobm_stop_cell
// One stop cell: keeps the oldest pending stop seen so far along the chain.
// ----------------------------------------------------------------------------
module lobm_stop_cell #(
	parameter int IDX = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lobm_pkg::stop_t      ent,
	input  logic [31:0]          arrival,
	input  lobm_pkg::sbest_t     best_in,
	output lobm_pkg::sbest_t     best_q
);
	logic [31:0]      age;
	lobm_pkg::sbest_t nxt;

	always_comb begin
		age = arrival - ent.seq;
		nxt = best_in;
		if (ent.pend && (!best_in.found || age > best_in.age)) begin
			nxt.found = 1'b1;
			nxt.idx   = 4'(IDX);
			nxt.age   = age;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= '0;
		end else begin
			best_q <= nxt;
		end
	end
endmodule

// File: rtl/limit_order_book_matcher.sv
// ----------------------------------------------------------------------------
// limit_order_book_matcher
// Price-time priority order book with market, limit and stop-loss orders.
// ----------------------------------------------------------------------------
// Usage: one order is taken per in_valid/in_ready transfer. The block answers
// with zero or more fill records (kind 0) and then one done record (kind 1,
// last 1) on the out_valid/out_ready channel. A new order is taken once the
// done record of the previous one has been loaded into the output register.
// The best maker is found by a chain of MAX_RESTING book cells, one cell per
// cycle; S_BEST waits for the chain to settle before each fill. Each stored
// stop is picked by a chain of MAX_STOPS stop cells and then tested in S_STEST.
// A stop order goes from idle straight to S_DONE, which loads its done record
// once the output register is free. A limit or market order that finds no
// maker and tests no stop passes S_BEST, S_FILL, S_REST and S_SPICK to S_DONE.
// The output register holds a record until taken; when the receiver stalls
// the search waits. Reset empties the book and stop list, clears the arrival
// counter and sets the last trade price to zero; no clearing pass is needed.
// ----------------------------------------------------------------------------
module limit_order_book_matcher #(
	parameter int MAX_RESTING = lobm_pkg::MAX_RESTING_DEF,
	parameter int MAX_STOPS   = lobm_pkg::MAX_STOPS_DEF,
	parameter int PRICE_TICKS = lobm_pkg::PRICE_TICKS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [31:0] order_id,
	input  logic [15:0] session_id,
	input  logic        is_buy,
	input  logic [9:0]  limit_price,
	input  logic [9:0]  stop_price,
	input  logic [31:0] quantity,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic [31:0] taker_id,
	output logic [15:0] taker_session,
	output logic [31:0] maker_id,
	output logic [15:0] maker_session,
	output logic [9:0]  fill_price,
	output logic [31:0] fill_quantity,
	output logic        taker_buys,
	output logic [2:0]  done_status,
	output logic        last
);
	localparam int RW = $clog2(MAX_RESTING);
	localparam int SW = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
	localparam int CW = $clog2(MAX_RESTING + MAX_STOPS + 2);
	localparam logic [9:0] PTOP = 10'(((PRICE_TICKS - 1) > 1023) ? 1023 : (PRICE_TICKS - 1));

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_BEST  = 3'd1;
	localparam logic [2:0] S_FILL  = 3'd2;
	localparam logic [2:0] S_REST  = 3'd3;
	localparam logic [2:0] S_SPICK = 3'd4;
	localparam logic [2:0] S_STEST = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	lobm_pkg::rest_t  book_q  [MAX_RESTING];
	lobm_pkg::stop_t  stops_q [MAX_STOPS];
	lobm_pkg::best_t  bchain  [MAX_RESTING+1];
	lobm_pkg::sbest_t schain  [MAX_STOPS+1];

	logic [2:0]  state_q;
	logic [CW-1:0] cnt_q;
	logic [31:0] arrival_q;
	logic [9:0]  ltp_q;
	logic [9:0]  ref_q;
	logic        stop_phase_q;
	// current taker
	logic [31:0] id_q, tid_q;
	logic [15:0] ses_q, tses_q;
	logic        buy_q, tbuy_q, tlim_q;
	logic [9:0]  lim_q;
	logic [9:0]  sprice_q;
	logic [31:0] qty_q;
	logic [2:0]  status_q;
	lobm_pkg::best_t  bsel_q;

	logic [9:0]  lim_c, stp_c;
	logic        rfree, sfree;
	logic [RW-1:0] rslot;
	logic [SW-1:0] sslot;
	logic        out_free;
	logic        out_load;
	logic [31:0] mq, tq;
	logic        cross_ok;

	assign bchain[0] = '0;
	assign schain[0] = '0;

	genvar g;
	generate
		for (g = 0; g < MAX_RESTING; g++) begin : g_book
			lobm_book_cell #(.IDX(g)) u_cell (
				.clk(clk), .arst_n(arst_n), .ent(book_q[g]), .taker_buy(tbuy_q),
				.arrival(arrival_q), .best_in(bchain[g]), .best_q(bchain[g+1])
			);
		end
		for (g = 0; g < MAX_STOPS; g++) begin : g_stop
			lobm_stop_cell #(.IDX(g)) u_cell (
				.clk(clk), .arst_n(arst_n), .ent(stops_q[g]), .arrival(arrival_q),
				.best_in(schain[g]), .best_q(schain[g+1])
			);
		end
	endgenerate

	always_comb begin
		lim_c = (limit_price > PTOP) ? PTOP : limit_price;
		stp_c = (stop_price > PTOP) ? PTOP : stop_price;
		rfree = 1'b0;
		rslot = '0;
		for (int i = MAX_RESTING - 1; i >= 0; i--) begin
			if (!book_q[i].vld) begin
				rfree = 1'b1;
				rslot = RW'(i);
			end
		end
		sfree = 1'b0;
		sslot = '0;
		for (int i = MAX_STOPS - 1; i >= 0; i--) begin
			if (!stops_q[i].vld) begin
				sfree = 1'b1;
				sslot = SW'(i);
			end
		end
		out_free = !out_valid || out_ready;
		mq = book_q[bsel_q.idx[RW-1:0]].qty;
		tq = (qty_q < mq) ? qty_q : mq;
		cross_ok = !tlim_q || (tbuy_q ? (lim_q >= bsel_q.price) : (lim_q <= bsel_q.price));
		out_load = ((state_q == S_FILL) && bsel_q.found && cross_ok && out_free) ||
			((state_q == S_DONE) && out_free);
	end

	assign in_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
			arrival_q <= '0;
			ltp_q     <= '0;
			cnt_q     <= '0;
			for (int i = 0; i < MAX_RESTING; i++) begin
				book_q[i].vld <= 1'b0;
			end
			for (int i = 0; i < MAX_STOPS; i++) begin
				stops_q[i].vld  <= 1'b0;
				stops_q[i].pend <= 1'b0;
			end
		end else begin
			if (out_valid && out_ready && !out_load) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						id_q   <= order_id;
						ses_q  <= session_id;
						buy_q  <= is_buy;
						tid_q  <= order_id;
						tses_q <= session_id;
						tbuy_q <= is_buy;
						tlim_q <= (func == lobm_pkg::FUNC_LIMIT);
						lim_q  <= lim_c;
						qty_q  <= quantity;
						stop_phase_q <= 1'b0;
						status_q <= lobm_pkg::ST_NO_REST;
						cnt_q  <= '0;
						if (func == lobm_pkg::FUNC_STOP) begin
							if (sfree) begin
								stops_q[sslot].vld   <= 1'b1;
								stops_q[sslot].pend  <= 1'b0;
								stops_q[sslot].id    <= order_id;
								stops_q[sslot].ses   <= session_id;
								stops_q[sslot].buy   <= is_buy;
								stops_q[sslot].price <= stp_c;
								stops_q[sslot].qty   <= quantity;
								stops_q[sslot].seq   <= arrival_q;
								arrival_q <= arrival_q + 32'd1;
								status_q  <= lobm_pkg::ST_STOP_STORE;
							end else begin
								status_q  <= lobm_pkg::ST_STOPS_FULL;
							end
							state_q <= S_DONE;
						end else if (func == lobm_pkg::FUNC_LIMIT ||
								func == lobm_pkg::FUNC_MARKET) begin
							state_q <= S_BEST;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_BEST: begin
					// wait for the book chain to settle with the current taker
					if (qty_q == '0) begin
						state_q <= S_REST;
					end else if (cnt_q == CW'(MAX_RESTING)) begin
						bsel_q  <= bchain[MAX_RESTING];
						state_q <= S_FILL;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_FILL: begin
					if (!bsel_q.found || !cross_ok) begin
						state_q <= S_REST;
					end else if (out_free) begin
						out_valid     <= 1'b1;
						kind          <= 1'b0;
						taker_id      <= tid_q;
						taker_session <= tses_q;
						maker_id      <= book_q[bsel_q.idx[RW-1:0]].id;
						maker_session <= book_q[bsel_q.idx[RW-1:0]].ses;
						fill_price    <= bsel_q.price;
						fill_quantity <= tq;
						taker_buys    <= tbuy_q;
						done_status   <= lobm_pkg::ST_RESTED;
						last          <= 1'b0;
						ltp_q         <= bsel_q.price;
						qty_q         <= qty_q - tq;
						book_q[bsel_q.idx[RW-1:0]].qty <= mq - tq;
						if (mq == tq) begin
							book_q[bsel_q.idx[RW-1:0]].vld <= 1'b0;
						end
						cnt_q   <= '0;
						state_q <= S_BEST;
					end
				end
				S_REST: begin
					if (!stop_phase_q) begin
						if (tlim_q && qty_q != '0) begin
							if (rfree) begin
								book_q[rslot].vld   <= 1'b1;
								book_q[rslot].id    <= tid_q;
								book_q[rslot].ses   <= tses_q;
								book_q[rslot].buy   <= tbuy_q;
								book_q[rslot].price <= lim_q;
								book_q[rslot].qty   <= qty_q;
								book_q[rslot].seq   <= arrival_q;
								arrival_q <= arrival_q + 32'd1;
								status_q  <= lobm_pkg::ST_RESTED;
							end else begin
								status_q  <= lobm_pkg::ST_BOOK_FULL;
							end
						end
						ref_q <= ltp_q;
						for (int i = 0; i < MAX_STOPS; i++) begin
							stops_q[i].pend <= stops_q[i].vld;
						end
						stop_phase_q <= 1'b1;
					end
					cnt_q   <= '0;
					state_q <= S_SPICK;
				end
				S_SPICK: begin
					if (cnt_q == CW'(MAX_STOPS)) begin
						if (schain[MAX_STOPS].found) begin
							stops_q[schain[MAX_STOPS].idx[SW-1:0]].pend <= 1'b0;
							tid_q    <= stops_q[schain[MAX_STOPS].idx[SW-1:0]].id;
							tses_q   <= stops_q[schain[MAX_STOPS].idx[SW-1:0]].ses;
							tbuy_q   <= stops_q[schain[MAX_STOPS].idx[SW-1:0]].buy;
							sprice_q <= stops_q[schain[MAX_STOPS].idx[SW-1:0]].price;
							qty_q    <= stops_q[schain[MAX_STOPS].idx[SW-1:0]].qty;
							bsel_q.idx <= 5'(schain[MAX_STOPS].idx);
							tlim_q   <= 1'b0;
							state_q  <= S_STEST;
						end else begin
							state_q <= S_DONE;
						end
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_STEST: begin
					cnt_q <= '0;
					if (tbuy_q ? (ref_q >= sprice_q) : (ref_q <= sprice_q)) begin
						stops_q[bsel_q.idx[SW-1:0]].vld <= 1'b0;
						state_q <= S_BEST;
					end else begin
						state_q <= S_SPICK;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid     <= 1'b1;
						kind          <= 1'b1;
						taker_id      <= id_q;
						taker_session <= ses_q;
						maker_id      <= '0;
						maker_session <= '0;
						fill_price    <= '0;
						fill_quantity <= '0;
						taker_buys    <= buy_q;
						done_status   <= status_q;
						last          <= 1'b1;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule
